// File: hdl/ouart_pkg.sv
// Shared types and constants for the oversampled UART receiver.
// No dependencies; imported by every module of the block.
package ouart_pkg;

  // Receive buffer geometry.
  localparam int BUF_LEN = 64;
  localparam int ADDR_W  = $clog2(BUF_LEN);
  localparam int POS_W   = ADDR_W + 1;

  // Register widths.
  localparam int BAUD_W  = 4;
  localparam int FLEN_W  = 7;
  localparam int CFG_W   = FLEN_W;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W  = 8;
  localparam int TICK_W  = 8;
  localparam int PHASE_W = 4;

  // Width that holds a position or a frame length plus one more bit.
  localparam int SUM_W = ((POS_W > FLEN_W) ? POS_W : FLEN_W) + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BAUD_DIV  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = CFG_IDX_W'(1);

  // Reset values of the registers.
  localparam logic [BAUD_W-1:0] BAUD_DIV_RST  = BAUD_W'(8);
  localparam logic [FLEN_W-1:0] FRAME_LEN_RST = FLEN_W'(8);

  // Bit phase codes; every code from PH_STOP up acts as the stop phase.
  localparam logic [PHASE_W-1:0] PH_IDLE  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_START = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_BIT0  = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_STOP  = PHASE_W'(10);

  // Each low sample in the start window adds this to the tick counter.
  localparam logic [TICK_W-1:0] START_LOW_INC = TICK_W'(8'h10);

  typedef struct packed {
    logic              write_valid;
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] write_addr;
    logic              frame_ready;
  } result_t;

endpackage

// File: hdl/oversampled_uart_receiver.sv
// Top level of the oversampled 8N1 UART receiver with buffer write output.
// Depends on ouart_pkg and ouart_core (which holds ouart_mod).
//
// Usage:
//   Input channel (in_valid / in_stall / rxd): one word per oversampling
//   tick, carrying the sampled receive line level.
//   Output channel (out_valid / out_stall / write_*, frame_ready): exactly
//   one word per input word. write_valid marks a received byte to be stored
//   at write_addr; otherwise write_data and write_addr are zero. frame_ready
//   is the frame-complete flag after that tick.
//   A word's result is registered (output register or skid entry) before it is offered.
//   Throughput: one tick per cycle while in_stall is low; the state update is a single pass of
//   compare and increment logic between the state registers.
//   Stall: a two-entry output buffer absorbs one result while out_stall is
//   high; in_stall rises when both entries are full or a remainder pass runs.
//   Reset (rst, synchronous): baud_div 8, frame_len 8, receiver idle, write
//   address 0, frame_ready low, output buffer empty.
//   Configuration (cfg_we / cfg_index / cfg_data): index 0 baud_div,
//   index 1 frame_len, other indexes dropped. A frame_len write starts a
//   remainder pass over the write position; in_stall stays high while it
//   runs, through its 7 bit steps and the final load of the remainder.
module oversampled_uart_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            rxd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            write_valid,
  output logic [ouart_pkg::DATA_W-1:0]    write_data,
  output logic [ouart_pkg::ADDR_W-1:0]    write_addr,
  output logic                            frame_ready,
  input  logic                            cfg_we,
  input  logic [ouart_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ouart_pkg::CFG_W-1:0]     cfg_data
);
  import ouart_pkg::*;

  logic    in_acc;
  logic    out_take;
  logic    core_busy;
  result_t core_res;

  // Output register and skid entry.
  result_t out_word;
  result_t skid_word;
  logic    skid_valid;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  // Hold input while the skid entry is full or the residue pass runs.
  assign in_stall = skid_valid || core_busy;

  ouart_core u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (in_acc),
    .rxd       (rxd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (core_busy),
    .res       (core_res)
  );

  // Control of the two-entry output buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input is stalled here: only drain.
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the output buffer.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_word <= core_res;
      end else begin
        out_word <= core_res;
      end
    end
  end

  assign write_valid = out_word.write_valid;
  assign write_data  = out_word.write_data;
  assign write_addr  = out_word.write_addr;
  assign frame_ready = out_word.frame_ready;

endmodule

// File: hdl/ouart_mod.sv
// Restoring remainder unit: one quotient bit a cycle.
// Depends on ouart_pkg.
module ouart_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ouart_pkg::POS_W-1:0]  dividend,
  input  logic [ouart_pkg::FLEN_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [ouart_pkg::POS_W-1:0]  rem
);
  import ouart_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [CNT_W-1:0]  steps;
  logic [POS_W-1:0]  dvd;
  logic [FLEN_W-1:0] dsr;
  logic [POS_W-1:0]  rem_acc;
  logic [SUM_W-1:0]  trial;
  logic [POS_W-1:0]  rem_acc_next;

  // Bring down the next dividend bit, subtract when it fits.
  always_comb begin
    trial = SUM_W'({rem_acc, dvd[POS_W-1]});
    if (trial >= SUM_W'(dsr)) begin
      rem_acc_next = POS_W'(trial - SUM_W'(dsr));
    end else begin
      rem_acc_next = POS_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= CNT_W'(POS_W);
      done  <= 1'b0;
    end else begin
      done <= (steps == CNT_W'(1));
      if (steps != '0) begin
        steps <= steps - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= dividend;
      dsr     <= divisor;
      rem_acc <= '0;
    end else if (steps != '0) begin
      dvd     <= {dvd[POS_W-2:0], 1'b0};
      rem_acc <= rem_acc_next;
    end
  end

  assign busy = (steps != '0) || done;
  assign rem  = rem_acc;

endmodule

// File: hdl/ouart_core.sv
// Receiver state and per-tick update: start check, bit sampling, stop,
// buffer address and frame tracking. Depends on ouart_pkg and ouart_mod.
module ouart_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           acc,
  input  logic                           rxd,
  input  logic                           cfg_we,
  input  logic [ouart_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ouart_pkg::CFG_W-1:0]     cfg_data,
  output logic                           busy,
  output ouart_pkg::result_t             res
);
  import ouart_pkg::*;

  logic [BAUD_W-1:0]  baud_div;
  logic [FLEN_W-1:0]  frame_len;
  logic [PHASE_W-1:0] bit_phase, bit_phase_next;
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic [DATA_W-1:0]  rx_shift, rx_shift_next;
  logic [POS_W-1:0]   write_pos, write_pos_next;
  logic [POS_W-1:0]   frame_residue, frame_residue_next;
  logic               ready_flag, ready_flag_next;

  logic [TICK_W-1:0]  tick_inc;
  logic [TICK_W-1:0]  start_tick;
  logic [TICK_W-1:0]  start_thr;
  logic [FLEN_W-1:0]  eff_len;
  logic               wrap;
  logic [POS_W-1:0]   pos0;
  logic [POS_W-1:0]   res0;
  logic [POS_W-1:0]   res_inc;
  logic               sample;
  logic               store;

  logic               len_write;
  logic [FLEN_W-1:0]  new_eff_len;
  logic               div_done;
  logic [POS_W-1:0]   div_rem;

  assign len_write   = cfg_we && (cfg_index == REG_FRAME_LEN);
  assign new_eff_len = (cfg_data == '0) ? FLEN_W'(1) : cfg_data;

  // Recompute the residue of the write position after a new frame length.
  ouart_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (len_write),
    .dividend (write_pos),
    .divisor  (new_eff_len),
    .busy     (busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    tick_inc   = tick_count + TICK_W'(1);
    start_tick = tick_inc + (rxd ? '0 : START_LOW_INC);
    start_thr  = {baud_div - BAUD_W'(2), 4'b0000} + TICK_W'(baud_div);
    eff_len    = (frame_len == '0) ? FLEN_W'(1) : frame_len;
    wrap       = (SUM_W'(write_pos) + SUM_W'(eff_len)) > SUM_W'(BUF_LEN);
    pos0       = wrap ? '0 : write_pos;
    res0       = wrap ? '0 : frame_residue;
    res_inc    = res0 + POS_W'(1);
  end

  always_comb begin
    bit_phase_next     = bit_phase;
    tick_count_next    = tick_count;
    rx_shift_next      = rx_shift;
    write_pos_next     = write_pos;
    frame_residue_next = frame_residue;
    ready_flag_next    = ready_flag;
    sample             = 1'b0;
    store              = 1'b0;
    res                = '0;

    if (acc) begin
      case (bit_phase)
        PH_IDLE: begin
          if (!rxd) begin
            ready_flag_next = 1'b0;
            bit_phase_next  = PH_START;
            tick_count_next = tick_inc;
          end
        end
        PH_START: begin
          // Low-sample count rides in the high nibble of the tick counter.
          if (start_tick[3:0] >= baud_div) begin
            bit_phase_next  = (start_tick >= start_thr) ? PH_BIT0 : PH_IDLE;
            tick_count_next = '0;
          end else begin
            tick_count_next = start_tick;
          end
        end
        PH_BIT0: begin
          tick_count_next = tick_inc;
          if (({1'b0, tick_inc} + 9'd1) >= 9'(baud_div)) begin
            sample = 1'b1;
          end
        end
        default: begin
          tick_count_next = tick_inc;
          if (bit_phase < PH_STOP) begin
            if (tick_inc >= TICK_W'(baud_div)) begin
              sample = 1'b1;
            end
          end else if (tick_inc == TICK_W'(baud_div)) begin
            store = rxd;
          end else if (tick_inc >= TICK_W'({baud_div, 1'b0})) begin
            store = 1'b1;
          end
        end
      endcase
    end

    if (sample) begin
      rx_shift_next   = {rxd, rx_shift[DATA_W-1:1]};
      bit_phase_next  = bit_phase + PHASE_W'(1);
      tick_count_next = '0;
    end

    if (store) begin
      res.write_valid = 1'b1;
      res.write_data  = rx_shift;
      res.write_addr  = pos0[ADDR_W-1:0];
      write_pos_next  = pos0 + POS_W'(1);
      if (SUM_W'(res_inc) >= SUM_W'(eff_len)) begin
        frame_residue_next = '0;
        ready_flag_next    = 1'b1;
      end else begin
        frame_residue_next = res_inc;
      end
      bit_phase_next  = PH_IDLE;
      tick_count_next = '0;
    end

    if (div_done) begin
      frame_residue_next = div_rem;
    end

    res.frame_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baud_div      <= BAUD_DIV_RST;
      frame_len     <= FRAME_LEN_RST;
      bit_phase     <= PH_IDLE;
      tick_count    <= '0;
      rx_shift      <= '0;
      write_pos     <= '0;
      frame_residue <= '0;
      ready_flag    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_BAUD_DIV)) begin
        baud_div <= cfg_data[BAUD_W-1:0];
      end
      if (len_write) begin
        frame_len <= cfg_data;
      end
      bit_phase     <= bit_phase_next;
      tick_count    <= tick_count_next;
      rx_shift      <= rx_shift_next;
      write_pos     <= write_pos_next;
      frame_residue <= frame_residue_next;
      ready_flag    <= ready_flag_next;
    end
  end

endmodule

// File: tb/tb_oversampled_uart_receiver.sv
// Self-checking testbench for the oversampled 8N1 UART receiver.
// Depends on ouart_pkg and the oversampled_uart_receiver top level; nothing else.
`timescale 1ns / 100ps

module tb_oversampled_uart_receiver;
  import ouart_pkg::*;

  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last expected word, to catch stray output words.
  localparam int DRAIN_CYCLES = 4;

  // Indexes past the register file; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic rxd = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic write_valid;
  logic [DATA_W-1:0] write_data;
  logic [ADDR_W-1:0] write_addr;
  logic frame_ready;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  oversampled_uart_receiver dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rxd         (rxd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .write_valid (write_valid),
    .write_data  (write_data),
    .write_addr  (write_addr),
    .frame_ready (frame_ready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Receiver mirror: registers and line-decoder state, updated once per
  // accepted tick word.
  // ---------------------------------------------------------------------------
  logic [BAUD_W-1:0]  rx_baud;
  logic [FLEN_W-1:0]  rx_flen;
  logic [PHASE_W-1:0] rx_phase;
  logic [TICK_W-1:0]  rx_tick;
  logic [DATA_W-1:0]  rx_shift;
  int                 buf_pos;
  int                 frame_fill;
  logic               ready_seen;

  // Per-tick results still owed by the block, oldest first.
  result_t tick_results_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  sent_ticks = 0;
  int  words_out = 0;
  int  rx_wait = 0;
  bit  rx_burst = 1'b0;
  bit  tx_burst = 1'b0;

  // A frame length of zero behaves as one.
  function automatic int frame_span();
    return (rx_flen == '0) ? 1 : int'(rx_flen);
  endfunction

  // Shift one data bit in, LSB first, and move to the next bit slot.
  function automatic void shift_bit(logic level);
    rx_shift = {level, rx_shift[DATA_W-1:1]};
    rx_phase = rx_phase + 1'b1;
    rx_tick  = '0;
  endfunction

  // Store the assembled byte: wrap when a whole frame no longer fits, then
  // advance the position and the frame fill count.
  function automatic logic [ADDR_W-1:0] commit_byte();
    int fl;
    logic [ADDR_W-1:0] addr;
    fl = frame_span();
    if (buf_pos + fl > BUF_LEN) begin
      buf_pos    = 0;
      frame_fill = 0;
    end
    addr = buf_pos[ADDR_W-1:0];
    buf_pos++;
    frame_fill++;
    if (frame_fill >= fl) begin
      frame_fill = 0;
      ready_seen = 1'b1;
    end
    rx_phase = PH_IDLE;
    rx_tick  = '0;
    return addr;
  endfunction

  // Advance the line decoder by one oversampling tick and return the word
  // the block must produce for it.
  function automatic result_t decode_tick(logic level);
    result_t r;
    logic [TICK_W-1:0] thr;
    r = '0;
    if (rx_phase == PH_IDLE) begin
      if (!level) begin
        ready_seen = 1'b0;
        rx_phase   = PH_START;
        rx_tick    = rx_tick + 1'b1;
      end
    end else if (rx_phase == PH_START) begin
      // Low nibble counts window ticks, high nibble counts low samples.
      rx_tick = rx_tick + 1'b1;
      if (!level) rx_tick = rx_tick + START_LOW_INC;
      if (rx_tick[3:0] >= rx_baud) begin
        thr      = {rx_baud - 4'd2, 4'd0} + {4'd0, rx_baud};
        rx_phase = (rx_tick >= thr) ? PH_BIT0 : PH_IDLE;
        rx_tick  = '0;
      end
    end else if (rx_phase == PH_BIT0) begin
      rx_tick = rx_tick + 1'b1;
      if (int'(rx_tick) >= int'(rx_baud) - 1) shift_bit(level);
    end else if (rx_phase < PH_STOP) begin
      rx_tick = rx_tick + 1'b1;
      if (rx_tick >= rx_baud) shift_bit(level);
    end else begin
      // Stop bit: take it early on a high sample, force it after two periods.
      rx_tick = rx_tick + 1'b1;
      if (rx_tick == rx_baud) begin
        if (level) begin
          r.write_valid = 1'b1;
          r.write_data  = rx_shift;
          r.write_addr  = commit_byte();
        end
      end else if (int'(rx_tick) >= 2 * int'(rx_baud)) begin
        r.write_valid = 1'b1;
        r.write_data  = rx_shift;
        r.write_addr  = commit_byte();
      end
    end
    r.frame_ready = ready_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: check output words, mirror register writes,
  // predict accepted tick words, and feed the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rx_baud    = BAUD_DIV_RST;
      rx_flen    = FRAME_LEN_RST;
      rx_phase   = PH_IDLE;
      rx_tick    = '0;
      rx_shift   = '0;
      buf_pos    = 0;
      frame_fill = 0;
      ready_seen = 1'b0;
      tick_results_q.delete();
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          $error("output word with no result expected");
          errors++;
        end else begin
          want = tick_results_q.pop_front();
          if (write_valid !== want.write_valid) begin
            $error("write_valid expected %0d got %0d", want.write_valid, write_valid);
            errors++;
          end
          if (write_data !== want.write_data) begin
            $error("write_data expected %02h got %02h", want.write_data, write_data);
            errors++;
          end
          if (write_addr !== want.write_addr) begin
            $error("write_addr expected %0d got %0d", want.write_addr, write_addr);
            errors++;
          end
          if (frame_ready !== want.frame_ready) begin
            $error("frame_ready expected %0d got %0d", want.frame_ready, frame_ready);
            errors++;
          end
        end
        // Draw the stall for the next word; now and then run without stalls.
        words_out++;
        if (words_out % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_BAUD_DIV: rx_baud = cfg_data[BAUD_W-1:0];
          REG_FRAME_LEN: begin
            rx_flen    = cfg_data[FLEN_W-1:0];
            frame_fill = buf_pos % frame_span();
          end
          default: ;
        endcase
      end

      if (in_valid && !in_stall) tick_results_q.push_back(decode_tick(rxd));

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Output side: hold stall for the drawn number of cycles, then release.
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hang detector.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("oversampled_uart_receiver test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one tick word after a random gap and hold it until taken.
  // Called and returns at a falling edge.
  task automatic send_tick(input logic level);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      rxd      <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rxd      <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_ticks++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed word is out, plus the output latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // One register write; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // A complete 8N1 frame at 'span' ticks per bit, with some clock skew and an
  // occasional stop bit held low.
  task automatic send_frame(input logic [DATA_W-1:0] value, input int span);
    int per_bit;
    per_bit = span;
    if (span >= 4 && $urandom_range(0, 7) == 0)
      per_bit = span + (($urandom_range(0, 1) == 1) ? 1 : -1);
    repeat ($urandom_range(0, span)) send_tick(1'b1);
    repeat (per_bit) send_tick(1'b0);
    for (int k = 0; k < DATA_W; k++) repeat (per_bit) send_tick(value[k]);
    if ($urandom_range(0, 7) == 0) repeat (2 * per_bit) send_tick(1'b0);
    repeat (per_bit) send_tick(1'b1);
  endtask

  // Mostly well-formed frames, the rest short start glitches and line noise.
  task automatic send_sequence(input int baud);
    int span;
    int pick;
    logic [DATA_W-1:0] value;
    span = (baud < 2) ? $urandom_range(2, 8) : baud;
    tx_burst = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      case ($urandom_range(0, 7))
        0: value = 8'h00;
        1: value = 8'hFF;
        default: value = 8'($urandom);
      endcase
      send_frame(value, span);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, span)) send_tick(1'b0);
      repeat (span) send_tick(1'b1);
    end else begin
      repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed script: one row holds an optional register write and a line level
  // held for some ticks. Where 'typed' is set, the word of the last tick is
  // checked against the value written in the row.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic                 level;
    int                   reps;
    logic                 typed;
    result_t              want;
  } step_row_t;

  // Frame 0xA5 at two ticks per bit, with frame length zero (every byte ends a
  // frame); then dropped writes to spare indexes; then divisor zero, where
  // every start bit is rejected.
  step_row_t script [16] = '{
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b1, REG_BAUD_DIV,  7'h72, 1'b1, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b1, REG_FRAME_LEN, 7'h00, 1'b1, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b0, 2, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 1, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b0, 2, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 2, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b0, 4, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 2, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b0, 2, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 4, 1'b1, '{1'b1, 8'hA5, 6'd0, 1'b1}},
    '{1'b1, REG_SPARE_A,   7'h55, 1'b1, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b1}},
    '{1'b1, REG_SPARE_B,   7'h2A, 1'b1, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b1}},
    '{1'b1, REG_BAUD_DIV,  7'h70, 1'b0, 1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b0, 3, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}},
    '{1'b0, REG_BAUD_DIV,  7'h00, 1'b1, 1, 1'b0, '{1'b0, 8'h00, 6'd0, 1'b0}}
  };

  // Random part: one register setting per leg. Large frame lengths come first
  // so the write position can later climb past the upper half of the buffer
  // before the forty-byte frame forces a wrap.
  typedef struct {
    int baud;
    int flen;
    int budget;
  } leg_t;

  leg_t plan [10] = '{
    '{15,  64,  40},
    '{ 4, 127,  80},
    '{ 2,   1, 600},
    '{ 3,   0,  90},
    '{ 2,   5, 140},
    '{ 6,  40, 100},
    '{ 1,   2,  30},
    '{ 0,   9,  30},
    '{ 2,  63,  60},
    '{ 3,   3,  90}
  };

  initial begin
    step_row_t row;
    int start;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      row = script[i];
      if (row.wr) begin
        settle();
        write_reg(row.idx, row.data);
      end
      repeat (row.reps) send_tick(row.level);
      // The last tick's word is still queued: replace the mirror's value with
      // the one written in the row.
      if (row.typed) tick_results_q[tick_results_q.size() - 1] = row.want;
    end

    foreach (plan[p]) begin
      // Hold off until the block has delivered everything, then reconfigure.
      // Junk in the upper data bits checks that the divisor write is masked.
      settle();
      write_reg(REG_BAUD_DIV, {3'($urandom_range(0, 7)), 4'(plan[p].baud)});
      write_reg(REG_FRAME_LEN, 7'(plan[p].flen));
      start = sent_ticks;
      while (sent_ticks - start < plan[p].budget)
        send_sequence(plan[p].baud);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("oversampled_uart_receiver test passed");
    else
      $display("oversampled_uart_receiver test failed");
    $finish;
  end

endmodule
